// File: hdl/snfcf_pkg.sv
// Shared types, opcode constants and the microcode program of the SPI NOR command framer.
// Used by the sequencer, the datapath and the top level; depends on nothing else.
package snfcf_pkg;

   localparam int PC_W       = 5;
   localparam int MAX_FRAMES = 36;
   localparam int FC_W       = 6;

   // SPI command bytes.
   localparam logic [7:0] OPC_WREN      = 8'h06;
   localparam logic [7:0] OPC_WRDI      = 8'h04;
   localparam logic [7:0] OPC_RDSR      = 8'h05;
   localparam logic [7:0] OPC_WRSR      = 8'h01;
   localparam logic [7:0] OPC_RDFLAG    = 8'h70;
   localparam logic [7:0] OPC_RDID      = 8'h9F;
   localparam logic [7:0] OPC_READ      = 8'h03;
   localparam logic [7:0] OPC_FAST_READ = 8'h0B;
   localparam logic [7:0] OPC_PP        = 8'h02;
   localparam logic [7:0] OPC_SSE       = 8'h20;
   localparam logic [7:0] OPC_SE        = 8'hD8;
   localparam logic [7:0] OPC_BE        = 8'hC7;
   localparam logic [7:0] OPC_RSTEN     = 8'h66;

   // Data direction codes of a frame.
   localparam logic [1:0] DIR_NONE  = 2'd0;
   localparam logic [1:0] DIR_WRITE = 2'd1;
   localparam logic [1:0] DIR_READ  = 2'd2;

   // Request codes.
   typedef enum logic [3:0] {
      REQ_WREN, REQ_WRDI, REQ_RDSR, REQ_WRSR, REQ_RDFLAG, REQ_RDID,
      REQ_READ, REQ_PROGRAM, REQ_SSE, REQ_SE, REQ_BE, REQ_RSTEN
   } req_op_type;

   // Opcode selector of a control word; OPS_READ picks normal or fast read in the datapath.
   typedef enum logic [3:0] {
      OPS_WREN, OPS_WRDI, OPS_RDSR, OPS_WRSR, OPS_RDFLAG, OPS_RDID,
      OPS_READ, OPS_PP, OPS_SSE, OPS_SE, OPS_BE, OPS_RSTEN
   } opc_sel_type;

   typedef enum logic [2:0] {
      LEN_ZERO, LEN_ONE, LEN_THREE, LEN_REQ, LEN_CHUNK
   } len_sel_type;

   typedef enum logic [2:0] {
      SEQ_NEXT, SEQ_END, SEQ_GOTO, SEQ_SKIP_IF_DONE, SEQ_WAIT_MOD
   } seq_type;

   typedef struct packed {
      logic             emit;
      opc_sel_type      opc;
      logic             has_addr;
      logic [1:0]       dir;
      len_sel_type      len_sel;
      logic             inline_en;
      logic             wait_rdy;
      seq_type          seq;
      logic [PC_W-1:0]  target;
   } ucode_word_type;

   typedef struct packed {
      logic           fire;
      logic           load_off;
      logic           last;
      ucode_word_type cw;
   } step_ctl_type;

   typedef struct packed {
      logic            valid;
      logic [PC_W-1:0] pc;
   } entry_type;

   // Program entry points and jump targets.
   localparam logic [PC_W-1:0] PC_WREN    = 5'd0;
   localparam logic [PC_W-1:0] PC_WRDI    = 5'd1;
   localparam logic [PC_W-1:0] PC_RDSR    = 5'd2;
   localparam logic [PC_W-1:0] PC_WRSR    = 5'd3;
   localparam logic [PC_W-1:0] PC_RDFLAG  = 5'd5;
   localparam logic [PC_W-1:0] PC_RDID    = 5'd6;
   localparam logic [PC_W-1:0] PC_READ    = 5'd7;
   localparam logic [PC_W-1:0] PC_PGM     = 5'd8;
   localparam logic [PC_W-1:0] PC_PGM_TST = 5'd9;
   localparam logic [PC_W-1:0] PC_PGM_END = 5'd12;
   localparam logic [PC_W-1:0] PC_SSE     = 5'd13;
   localparam logic [PC_W-1:0] PC_SE      = 5'd16;
   localparam logic [PC_W-1:0] PC_BE      = 5'd19;
   localparam logic [PC_W-1:0] PC_RSTEN   = 5'd22;

   function automatic ucode_word_type uw(input logic emit, input opc_sel_type opc,
                                         input logic has_addr, input logic [1:0] dir,
                                         input len_sel_type len_sel, input logic inline_en,
                                         input logic wait_rdy, input seq_type seq,
                                         input logic [PC_W-1:0] target);
      ucode_word_type w;
      w.emit      = emit;
      w.opc       = opc;
      w.has_addr  = has_addr;
      w.dir       = dir;
      w.len_sel   = len_sel;
      w.inline_en = inline_en;
      w.wait_rdy  = wait_rdy;
      w.seq       = seq;
      w.target    = target;
      return w;
   endfunction

   // The control store: one word per step.
   function automatic ucode_word_type ucode(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      unique case (pc)
         5'd0:  w = uw(1'b1, OPS_WREN,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_END, '0);
         5'd1:  w = uw(1'b1, OPS_WRDI,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_END, '0);
         5'd2:  w = uw(1'b1, OPS_RDSR,   1'b0, DIR_READ,  LEN_ONE,   1'b0, 1'b0, SEQ_END, '0);
         5'd3:  w = uw(1'b1, OPS_WREN,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_NEXT, '0);
         5'd4:  w = uw(1'b1, OPS_WRSR,   1'b0, DIR_WRITE, LEN_ONE,   1'b1, 1'b0, SEQ_END, '0);
         5'd5:  w = uw(1'b1, OPS_RDFLAG, 1'b0, DIR_READ,  LEN_ONE,   1'b0, 1'b0, SEQ_END, '0);
         5'd6:  w = uw(1'b1, OPS_RDID,   1'b0, DIR_READ,  LEN_THREE, 1'b0, 1'b0, SEQ_END, '0);
         5'd7:  w = uw(1'b1, OPS_READ,   1'b1, DIR_READ,  LEN_REQ,   1'b0, 1'b0, SEQ_END, '0);
         5'd8:  w = uw(1'b0, OPS_WREN,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0,
                       SEQ_WAIT_MOD, '0);
         5'd9:  w = uw(1'b0, OPS_WREN,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0,
                       SEQ_SKIP_IF_DONE, PC_PGM_END);
         5'd10: w = uw(1'b1, OPS_WREN,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_NEXT, '0);
         5'd11: w = uw(1'b1, OPS_PP,     1'b1, DIR_WRITE, LEN_CHUNK, 1'b0, 1'b1,
                       SEQ_GOTO, PC_PGM_TST);
         5'd12: w = uw(1'b1, OPS_WRDI,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_END, '0);
         5'd13: w = uw(1'b1, OPS_WREN,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_NEXT, '0);
         5'd14: w = uw(1'b1, OPS_SSE,    1'b1, DIR_NONE,  LEN_ZERO,  1'b0, 1'b1, SEQ_NEXT, '0);
         5'd15: w = uw(1'b1, OPS_WRDI,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_END, '0);
         5'd16: w = uw(1'b1, OPS_WREN,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_NEXT, '0);
         5'd17: w = uw(1'b1, OPS_SE,     1'b1, DIR_NONE,  LEN_ZERO,  1'b0, 1'b1, SEQ_NEXT, '0);
         5'd18: w = uw(1'b1, OPS_WRDI,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_END, '0);
         5'd19: w = uw(1'b1, OPS_WREN,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_NEXT, '0);
         5'd20: w = uw(1'b1, OPS_BE,     1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b1, SEQ_NEXT, '0);
         5'd21: w = uw(1'b1, OPS_WRDI,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_END, '0);
         5'd22: w = uw(1'b1, OPS_WREN,   1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_NEXT, '0);
         5'd23: w = uw(1'b1, OPS_RSTEN,  1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_END, '0);
         default: w = uw(1'b0, OPS_WREN, 1'b0, DIR_NONE,  LEN_ZERO,  1'b0, 1'b0, SEQ_END, '0);
      endcase
      return w;
   endfunction

   function automatic entry_type entry_pc(input logic [3:0] op);
      entry_type e;
      e.valid = 1'b1;
      unique case (op)
         REQ_WREN:    e.pc = PC_WREN;
         REQ_WRDI:    e.pc = PC_WRDI;
         REQ_RDSR:    e.pc = PC_RDSR;
         REQ_WRSR:    e.pc = PC_WRSR;
         REQ_RDFLAG:  e.pc = PC_RDFLAG;
         REQ_RDID:    e.pc = PC_RDID;
         REQ_READ:    e.pc = PC_READ;
         REQ_PROGRAM: e.pc = PC_PGM;
         REQ_SSE:     e.pc = PC_SSE;
         REQ_SE:      e.pc = PC_SE;
         REQ_BE:      e.pc = PC_BE;
         REQ_RSTEN:   e.pc = PC_RSTEN;
         default: begin
            e.valid = 1'b0;
            e.pc    = PC_WREN;
         end
      endcase
      return e;
   endfunction

   function automatic logic [7:0] opcode_byte(input opc_sel_type s, input logic fast);
      logic [7:0] b;
      unique case (s)
         OPS_WREN:   b = OPC_WREN;
         OPS_WRDI:   b = OPC_WRDI;
         OPS_RDSR:   b = OPC_RDSR;
         OPS_WRSR:   b = OPC_WRSR;
         OPS_RDFLAG: b = OPC_RDFLAG;
         OPS_RDID:   b = OPC_RDID;
         OPS_READ:   b = fast ? OPC_FAST_READ : OPC_READ;
         OPS_PP:     b = OPC_PP;
         OPS_SSE:    b = OPC_SSE;
         OPS_SE:     b = OPC_SE;
         OPS_BE:     b = OPC_BE;
         OPS_RSTEN:  b = OPC_RSTEN;
         default:    b = OPC_WREN;
      endcase
      return b;
   endfunction

endpackage

// File: hdl/snfcf_addr_mod.sv
// Iterative reduction of a 32-bit address modulo the page size, four bits per cycle.
// Standalone unit; depends on nothing else.
module snfcf_addr_mod #(
   parameter int PAGE_SIZE = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [31:0]                  value,
   output logic                         done,
   output logic [$clog2(PAGE_SIZE)-1:0] offset
);

   localparam int OFF_W   = $clog2(PAGE_SIZE);
   localparam int RW      = OFF_W + 1;
   localparam int DIGIT_W = 4;
   localparam int STEPS   = 32 / DIGIT_W;
   localparam int CNT_W   = $clog2(STEPS);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      sh_ff, sh_in;
   logic [OFF_W-1:0] r_ff, r_in;
   logic [RW-1:0]    r_acc;

   always_comb begin
      r_acc = {1'b0, r_ff};
      for (int i = 0; i < DIGIT_W; i++) begin
         r_acc = {r_acc[RW-2:0], sh_ff[31-i]};
         if (r_acc >= RW'(PAGE_SIZE)) begin
            r_acc = r_acc - RW'(PAGE_SIZE);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = value;
         r_in    = '0;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[31-DIGIT_W:0], {DIGIT_W{1'b0}}};
         r_in   = r_acc[OFF_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff <= sh_in;
      r_ff  <= r_in;
   end

   assign done   = !busy_ff;
   assign offset = r_ff;

endmodule

// File: hdl/snfcf_sequencer.sv
// Microcode sequencer: step counter, control-store fetch, jumps and frame count.
// Depends on snfcf_pkg for the control store and control types.
module snfcf_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [3:0]                 op,
   input  logic                       out_free,
   input  logic                       mod_done,
   input  logic                       rem_zero,
   output logic                       busy,
   output snfcf_pkg::step_ctl_type    ctl
);

   logic                            busy_ff, busy_in;
   logic [snfcf_pkg::PC_W-1:0]      pc_ff, pc_in;
   logic [snfcf_pkg::FC_W-1:0]      fc_ff, fc_in;
   snfcf_pkg::ucode_word_type       cw;
   snfcf_pkg::entry_type            entry;
   logic                            adv, step, fire, cap, last;

   always_comb begin
      cw    = snfcf_pkg::ucode(pc_ff);
      entry = snfcf_pkg::entry_pc(op);
      if (cw.emit) begin
         adv = out_free;
      end else if (cw.seq == snfcf_pkg::SEQ_WAIT_MOD) begin
         adv = mod_done;
      end else begin
         adv = 1'b1;
      end
      step = busy_ff && adv;
      fire = step && cw.emit;
      // The frame budget is exhausted on the last allowed frame: it closes the run.
      cap  = (fc_ff == snfcf_pkg::FC_W'(snfcf_pkg::MAX_FRAMES - 1));
      last = (cw.seq == snfcf_pkg::SEQ_END) || cap;
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      fc_in   = fc_ff;
      if (accept) begin
         busy_in = entry.valid;
         pc_in   = entry.pc;
         fc_in   = '0;
      end else if (step) begin
         if (fire) begin
            fc_in = fc_ff + 1'b1;
         end
         if (fire && last) begin
            busy_in = 1'b0;
         end else begin
            unique case (cw.seq)
               snfcf_pkg::SEQ_GOTO:         pc_in = cw.target;
               snfcf_pkg::SEQ_SKIP_IF_DONE: pc_in = rem_zero ? cw.target : pc_ff + 1'b1;
               snfcf_pkg::SEQ_END:          busy_in = 1'b0;
               default:                     pc_in = pc_ff + 1'b1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
         fc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         fc_ff   <= fc_in;
      end
   end

   always_comb begin
      ctl.fire     = fire;
      ctl.load_off = step && (cw.seq == snfcf_pkg::SEQ_WAIT_MOD);
      ctl.last     = last;
      ctl.cw       = cw;
   end

   assign busy = busy_ff;

endmodule

// File: hdl/snfcf_datapath.sv
// Request registers, page-chunk arithmetic and frame field formation.
// Depends on snfcf_pkg; driven by the control word from snfcf_sequencer.
module snfcf_datapath #(
   parameter int PAGE_SIZE = 256,
   parameter int MAX_LEN   = 4096
) (
   input  logic                         clock,
   input  logic                         accept,
   input  logic [31:0]                  req_address,
   input  logic [12:0]                  req_length,
   input  logic [7:0]                   req_status,
   input  logic                         four_byte,
   input  logic [$clog2(PAGE_SIZE)-1:0] mod_off,
   input  snfcf_pkg::step_ctl_type      ctl,
   output logic                         rem_zero,
   output logic [7:0]                   opcode,
   output logic [31:0]                  frame_address,
   output logic [2:0]                   addr_bytes,
   output logic                         dummy_byte,
   output logic [1:0]                   data_dir,
   output logic [12:0]                  data_len,
   output logic [7:0]                   inline_byte,
   output logic                         wait_ready
);

   localparam int OFF_W  = $clog2(PAGE_SIZE);
   localparam int ROOM_W = OFF_W + 1;
   localparam logic [32:0] ADDR_SPAN = 33'h1_0000_0000;
   // Offset shift of the page grid when the address wraps past the top.
   localparam int WRAP_K = int'(ADDR_SPAN % PAGE_SIZE);

   logic [31:0]       addr_ff, addr_in;
   logic [12:0]       rem_ff, rem_in;
   logic [12:0]       len_ff, len_in;
   logic [7:0]        sv_ff, sv_in;
   logic [OFF_W-1:0]  off_ff, off_in;

   logic [12:0]       clipped, room13, chunk;
   logic [ROOM_W-1:0] room, off_sum, off_wrap;
   logic [32:0]       addr_sum;
   logic              fast, pp_step;

   always_comb begin
      clipped = ({1'b0, req_length} > 14'(MAX_LEN)) ? 13'(MAX_LEN) : req_length;
      fast    = {1'b0, len_ff} > 14'(PAGE_SIZE);
      room    = ROOM_W'(PAGE_SIZE) - {1'b0, off_ff};
      room13  = 13'(room);
      chunk   = (rem_ff < room13) ? rem_ff : room13;
      addr_sum = {1'b0, addr_ff} + {20'b0, chunk};
      off_sum  = {1'b0, off_ff} + chunk[ROOM_W-1:0];
      off_wrap = (off_sum == ROOM_W'(PAGE_SIZE)) ? '0 : off_sum;
      if (addr_sum[32]) begin
         if (off_wrap >= ROOM_W'(WRAP_K)) begin
            off_wrap = off_wrap - ROOM_W'(WRAP_K);
         end else begin
            off_wrap = off_wrap + ROOM_W'(PAGE_SIZE) - ROOM_W'(WRAP_K);
         end
      end
      pp_step = ctl.fire && (ctl.cw.len_sel == snfcf_pkg::LEN_CHUNK);
   end

   always_comb begin
      addr_in = addr_ff;
      rem_in  = rem_ff;
      len_in  = len_ff;
      sv_in   = sv_ff;
      off_in  = off_ff;
      if (accept) begin
         addr_in = req_address;
         rem_in  = clipped;
         len_in  = clipped;
         sv_in   = req_status;
      end else begin
         if (ctl.load_off) begin
            off_in = mod_off;
         end
         if (pp_step) begin
            addr_in = addr_sum[31:0];
            rem_in  = rem_ff - chunk;
            off_in  = off_wrap[OFF_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      len_ff  <= len_in;
      sv_ff   <= sv_in;
      off_ff  <= off_in;
   end

   always_comb begin
      rem_zero   = (rem_ff == '0);
      opcode     = snfcf_pkg::opcode_byte(ctl.cw.opc, fast);
      dummy_byte = (ctl.cw.opc == snfcf_pkg::OPS_READ) && fast;
      data_dir   = ctl.cw.dir;
      wait_ready = ctl.cw.wait_rdy;
      inline_byte = ctl.cw.inline_en ? sv_ff : 8'h00;
      if (ctl.cw.has_addr) begin
         frame_address = four_byte ? addr_ff : {8'h00, addr_ff[23:0]};
         addr_bytes    = four_byte ? 3'd4 : 3'd3;
      end else begin
         frame_address = '0;
         addr_bytes    = 3'd0;
      end
      case (ctl.cw.len_sel)
         snfcf_pkg::LEN_ONE:   data_len = 13'd1;
         snfcf_pkg::LEN_THREE: data_len = 13'd3;
         snfcf_pkg::LEN_REQ:   data_len = len_ff;
         snfcf_pkg::LEN_CHUNK: data_len = chunk;
         default:              data_len = '0;
      endcase
   end

endmodule

// File: hdl/spi_nor_flash_command_framer_core.sv
// After the request transfer the sequencer registers its entry step; each frame is then registered on rsp.
// Throughput: one sequencer step per cycle; a frame step stalls while rsp cannot take it,
// and a program request first waits for the page-offset reduction and adds one test step
// per page. Each frame takes one step.
// Reset (synchronous) clears the sequencer, the output valid and the address-mode register.
module spi_nor_flash_command_framer_core #(
   parameter int PAGE_SIZE = 256,
   parameter int MAX_LEN   = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // address[31:0], length[44:32], status_value[52:45], zero
   input  logic [3:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_address[31:0], addr_bytes[34:32], dummy_byte[35], data_dir[37:36],
   // data_len[50:38], inline_byte[58:51], wait_ready[59], zero
   output logic [63:0] rsp_tdata,
   output logic [7:0]  rsp_tuser,   // opcode
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   localparam int OFF_W = $clog2(PAGE_SIZE);

   logic                    four_byte_ff, four_byte_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]             rsp_tdata_ff, rsp_tdata_in;
   logic [7:0]              rsp_tuser_ff, rsp_tuser_in;
   logic                    rsp_tlast_ff, rsp_tlast_in;

   logic                    accept, busy, out_free, mod_done, rem_zero;
   logic [OFF_W-1:0]        mod_off;
   snfcf_pkg::step_ctl_type ctl;

   logic [7:0]              f_opcode, f_inline;
   logic [31:0]             f_addr;
   logic [2:0]              f_abytes;
   logic                    f_dummy, f_wait;
   logic [1:0]              f_dir;
   logic [12:0]             f_len;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   snfcf_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .op       (req_tuser),
      .out_free (out_free),
      .mod_done (mod_done),
      .rem_zero (rem_zero),
      .busy     (busy),
      .ctl      (ctl)
   );

   snfcf_addr_mod #(.PAGE_SIZE(PAGE_SIZE)) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .value  (req_tdata[31:0]),
      .done   (mod_done),
      .offset (mod_off)
   );

   snfcf_datapath #(.PAGE_SIZE(PAGE_SIZE), .MAX_LEN(MAX_LEN)) u_dp (
      .clock         (clock),
      .accept        (accept),
      .req_address   (req_tdata[31:0]),
      .req_length    (req_tdata[44:32]),
      .req_status    (req_tdata[52:45]),
      .four_byte     (four_byte_ff),
      .mod_off       (mod_off),
      .ctl           (ctl),
      .rem_zero      (rem_zero),
      .opcode        (f_opcode),
      .frame_address (f_addr),
      .addr_bytes    (f_abytes),
      .dummy_byte    (f_dummy),
      .data_dir      (f_dir),
      .data_len      (f_len),
      .inline_byte   (f_inline),
      .wait_ready    (f_wait)
   );

   always_comb begin
      four_byte_in  = csr_we ? csr_wdata : four_byte_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (ctl.fire) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {4'b0, f_wait, f_inline, f_len, f_dir, f_dummy, f_abytes, f_addr};
         rsp_tuser_in  = f_opcode;
         rsp_tlast_in  = ctl.last;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         four_byte_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         four_byte_ff  <= four_byte_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   // A frame is only loaded when the output register is empty or being drained.
   a_fire_free: assert property (@(posedge clock) disable iff (reset)
      ctl.fire |-> out_free)
      else $error("frame loaded over an untaken result");

   // A request with a defined code keeps the block busy in the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser <= snfcf_pkg::REQ_RSTEN)) |=> !req_tready)
      else $error("block idle right after a valid request transfer");

   // The page offset is taken only once the reduction unit has finished.
   a_off_ready: assert property (@(posedge clock) disable iff (reset)
      ctl.load_off |-> mod_done)
      else $error("page offset loaded before reduction finished");
`endif

endmodule
